[design/fir_pkg.sv]
// Shared access type and register offsets for the FIR register-interface engine.
package fir_pkg;

    localparam logic [7:0] OFF_CTRL = 8'h00;
    localparam logic [7:0] OFF_LEN  = 8'h10;
    localparam logic [7:0] OFF_TAP  = 8'h20;
    localparam logic [7:0] OFF_PUSH = 8'h80;
    localparam logic [7:0] OFF_POP  = 8'h84;

    // One bus access as it travels from the front to the back
    typedef struct packed {
        logic        command;
        logic [7:0]  address;
        logic [31:0] wr_value;
    } fir_access_t;

endpackage

[design/fir_front.sv]
// Input side: accept bus beats and queue them for the back end.
module fir_front
    import fir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fir_access_t in_access,
    output logic        q_valid,
    input  logic        q_ready,
    output fir_access_t q_access
);

    fir_access_t mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    logic push;
    logic pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_access = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Hold pointers and fill count of the two-entry queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Store the accepted beat
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_access;
    end

endmodule

[design/fir_back.sv]
// Back end: register file, sample ring and shared multiply-accumulate.
module fir_back
    import fir_pkg::*;
#(
    parameter int TAP_COUNT = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  fir_access_t q_access,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data
);

    localparam int IW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam logic [IW-1:0] LAST = IW'(TAP_COUNT - 1);

    typedef enum logic [1:0] { ST_IDLE, ST_MAC, ST_SCALE } state_t;

    state_t      state_reg;
    logic [31:0] tap_reg   [TAP_COUNT];
    logic [31:0] ring_reg  [TAP_COUNT];
    logic [TAP_COUNT-1:0] ring_ok_reg;
    logic [IW-1:0] newest_reg;
    logic [31:0] len_reg;
    logic [31:0] taken_reg;
    logic        start_reg;
    logic        done_reg;
    logic        idle_reg;
    logic        rvalid_reg;
    logic [31:0] hold_reg;
    logic [31:0] acc_reg;
    logic [IW-1:0] j_reg;
    logic [IW-1:0] k_reg;
    logic [31:0] prod_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic        cmd;
    logic [7:0]  addr;
    logic [31:0] wd;
    logic        tap_hit;
    logic [7:0]  tap_off;
    logic [IW-1:0] tap_idx;
    logic        sample_ready;
    logic [31:0] status;
    logic [IW-1:0] slot_next;
    logic [31:0] samp;
    logic        push_ok;
    logic [31:0] rd_data;

    assign cmd  = q_access.command;
    assign addr = q_access.address;
    assign wd   = q_access.wr_value;

    // Decode tap offsets
    assign tap_off = addr - OFF_TAP;
    assign tap_hit = (addr >= OFF_TAP) && (addr[1:0] == 2'b00)
                     && (tap_off[7:2] < 6'(TAP_COUNT));
    assign tap_idx = IW'(tap_off[7:2]);

    assign sample_ready = !idle_reg && !rvalid_reg && (taken_reg < len_reg);
    assign status = {26'd0, rvalid_reg, sample_ready, 1'b0, idle_reg, done_reg, start_reg};
    assign slot_next = (newest_reg == LAST) ? '0 : newest_reg + 1'b1;
    assign samp = ring_ok_reg[k_reg] ? ring_reg[k_reg] : 32'd0;
    assign push_ok = cmd && (addr == OFF_PUSH) && sample_ready;

    // Select read data; writes and unmapped offsets return zero
    always_comb
    begin
        rd_data = '0;
        if (!cmd)
        begin
            if (addr == OFF_CTRL)
                rd_data = status;
            else if (addr == OFF_LEN)
                rd_data = len_reg;
            else if (addr == OFF_POP)
                rd_data = hold_reg;
            else if (tap_hit)
                rd_data = tap_reg[tap_idx];
        end
    end

    assign q_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequence accesses and walk the MAC over the taps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ring_ok_reg   <= '0;
            newest_reg    <= '0;
            len_reg       <= '0;
            taken_reg     <= '0;
            start_reg     <= 1'b0;
            done_reg      <= 1'b0;
            idle_reg      <= 1'b1;
            rvalid_reg    <= 1'b0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TAP_COUNT; i++)
                tap_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        // An accepted push replies only when the MAC ends
                        out_valid_reg <= !push_ok;
                        out_data_reg  <= rd_data;
                        if (cmd)
                        begin
                            if (addr == OFF_CTRL)
                            begin
                                if (wd[0] && idle_reg)
                                begin
                                    ring_ok_reg <= '0;
                                    newest_reg  <= '0;
                                    taken_reg   <= '0;
                                    rvalid_reg  <= 1'b0;
                                    done_reg    <= (len_reg == 32'd0);
                                    start_reg   <= (len_reg != 32'd0);
                                    idle_reg    <= (len_reg == 32'd0);
                                end
                            end
                            else if (addr == OFF_LEN)
                            begin
                                if (idle_reg)
                                    len_reg <= wd;
                            end
                            else if (addr == OFF_PUSH)
                            begin
                                if (sample_ready)
                                begin
                                    // Shift sample in, hold result until MAC ends
                                    newest_reg            <= slot_next;
                                    ring_reg[slot_next]   <= wd;
                                    ring_ok_reg[slot_next] <= 1'b1;
                                    acc_reg               <= '0;
                                    j_reg                 <= '0;
                                    k_reg                 <= slot_next;
                                    state_reg             <= ST_SCALE;
                                end
                            end
                            else if (tap_hit && idle_reg)
                            begin
                                tap_reg[tap_idx] <= wd;
                            end
                        end
                        else
                        begin
                            if (addr == OFF_POP)
                                rvalid_reg <= 1'b0;
                        end
                    end
                end
                ST_SCALE:
                begin
                    // Register one product
                    prod_reg  <= 32'(tap_reg[j_reg] * samp);
                    state_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    // Accumulate and advance one tap
                    if (j_reg == LAST)
                    begin
                        hold_reg      <= acc_reg + prod_reg;
                        rvalid_reg    <= 1'b1;
                        start_reg     <= 1'b0;
                        taken_reg     <= taken_reg + 32'd1;
                        if (taken_reg + 32'd1 >= len_reg)
                        begin
                            done_reg <= 1'b1;
                            idle_reg <= 1'b1;
                        end
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        acc_reg   <= acc_reg + prod_reg;
                        j_reg     <= j_reg + 1'b1;
                        k_reg     <= (k_reg == '0) ? LAST : k_reg - 1'b1;
                        state_reg <= ST_SCALE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[design/fir_engine_register_interface_core.sv]
// Top level of the FIR engine behind bus registers.
//  channel | direction | tdata fields (low bit first)
//  s_axis  | in        | command[0], address[8:1], wr_value[40:9]
//  m_axis  | out       | read_data[31:0]
// An accepted beat is registered in the two-entry queue before the back end sees it.
// A register access has its reply valid from the edge at which the back end
// takes it; an accepted sample push first runs the shared multiply-accumulate,
// one multiply then one add per tap.
// The back end takes no new beat while its reply waits on m_axis_tready.
// rst_n clears all control state and the taps asynchronously.
module fir_engine_register_interface_core
    import fir_pkg::*;
#(
    parameter int TAP_COUNT = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // command, address, wr_value, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // read_data
);

    fir_access_t in_access;
    fir_access_t q_access;
    logic        q_valid;
    logic        q_ready;

    assign in_access.command  = s_axis_tdata[0];
    assign in_access.address  = s_axis_tdata[8:1];
    assign in_access.wr_value = s_axis_tdata[40:9];

    fir_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_access(in_access),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_access (q_access)
    );

    fir_back #(.TAP_COUNT(TAP_COUNT)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_access (q_access),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata)
    );

endmodule
